// ===== hdl/ulre_pkg.sv =====
// shared types and character codes for the uart receive ring line editor
package ulre_pkg;

   // control characters seen by the line editor
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_DEL = 8'h7f;

   // request kinds
   localparam logic REQ_RX_BYTE   = 1'b0;
   localparam logic REQ_READ_LINE = 1'b1;

   // line_capacity register width and reset value
   localparam int unsigned CAP_W = 7;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_DRAIN = 3'b010,
      ST_EMIT  = 3'b100
   } state_type;

   // decision of the edit unit for one ring byte
   typedef struct packed {
      logic finish;   // line terminator on a non-empty line
      logic erase;    // drop the last character
      logic append;   // store the byte at the current length
   } edit_type;

endpackage

// ===== hdl/ulre_line_edit.sv =====
// edit unit: classifies one ring byte against the current line state
module ulre_line_edit #(
   parameter int unsigned LEN_W = 6
) (
   input  logic [7:0]       ch,
   input  logic [LEN_W-1:0] line_len,
   input  logic [LEN_W-1:0] line_limit,
   output ulre_pkg::edit_type edit
);
   import ulre_pkg::*;

   logic is_end;
   logic is_erase;
   logic is_empty;

   // character classes
   always_comb begin
      is_end   = (ch == CH_CR) || (ch == CH_LF);
      is_erase = (ch == CH_BS) || (ch == CH_DEL);
      is_empty = (line_len == '0);
   end

   // terminators on an empty line and erase on an empty line do nothing
   always_comb begin
      edit.finish = is_end && !is_empty;
      edit.erase  = is_erase && !is_empty;
      edit.append = !is_end && !is_erase && (line_len < line_limit);
   end

endmodule

// ===== hdl/uart_rx_ring_line_editor.sv =====
// top level: receive ring fifo, line store and drain/emit sequencer
//
// A byte event (req_type 0) gives no result; the byte is dropped when the
// ring already holds RING_DEPTH-1 bytes. A read request (req_type 1) is
// accepted, then the edit unit consumes ring bytes one per cycle until a line
// finishes or the ring is seen empty, then the line characters are emitted
// one per cycle; there is a single ring read port. With line_capacity below
// two the request is answered right away and busy never rises. Results come
// out on rsp_valid one per cycle, with no way for the receiver to hold them
// off, so it must take every strobe. A request with no finished line gives
// one result with line_ready 0 and last 1. busy is high from the cycle after
// acceptance and falls in the cycle that the last result is on the ports.
// The line_capacity register may be written at any cycle the block is idle.
module uart_rx_ring_line_editor #(
   parameter int unsigned RING_DEPTH = 128,
   parameter int unsigned LINE_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_type,
   input  logic [7:0]                req_rx_data,
   // response channel
   output logic                      rsp_valid,
   output logic                      rsp_line_ready,
   output logic [7:0]                rsp_line_char,
   output logic [5:0]                rsp_char_index,
   output logic                      rsp_last,
   // configuration channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [ulre_pkg::CAP_W-1:0] csr_data
);
   import ulre_pkg::*;

   localparam int unsigned PTR_W = $clog2(RING_DEPTH);
   localparam int unsigned LEN_W = $clog2(LINE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CAP_W-1:0] CAP_MAX  = CAP_W'(LINE_DEPTH);
   localparam logic [CAP_W-1:0] CAP_MIN  = CAP_W'(2);

   // storage
   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] line_mem [LINE_DEPTH];

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] limit_ff, limit_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [7:0]       ring_rd_ff;
   logic [7:0]       line_rd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ready_ff, rsp_ready_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [LEN_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic [PTR_W-1:0] ring_rd_addr;
   logic [LEN_W-1:0] line_rd_addr;
   logic             ring_we;
   logic             line_we;
   edit_type         edit;

   // pointer increments with wrap at the ring depth
   always_comb begin
      head_next = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      tail_next = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   end

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // single edit unit, one ring byte per cycle
   ulre_line_edit #(
      .LEN_W(LEN_W)
   ) u_edit (
      .ch        (ring_rd_ff),
      .line_len  (len_ff),
      .line_limit(limit_ff),
      .edit      (edit)
   );

   // read addresses run one step ahead so data is ready when consumed
   always_comb begin
      ring_rd_addr = (state_ff == ST_DRAIN) ? tail_next : tail_ff;
      line_rd_addr = (state_ff == ST_EMIT) ? idx_ff + 1'b1 : '0;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      len_in       = len_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      cap_in       = cap_ff;
      ring_we      = 1'b0;
      line_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_ready_in = 1'b0;
      rsp_char_in  = '0;
      rsp_idx_in   = '0;
      rsp_last_in  = 1'b1;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_RX_BYTE) begin
                  if (head_next != tail_ff) begin
                     ring_we = 1'b1;
                     head_in = head_next;
                  end
               end else if (cap_ff < CAP_MIN) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  limit_in = (cap_ff >= CAP_MAX) ? LEN_W'(LINE_DEPTH - 1)
                                                 : LEN_W'(cap_ff - 1'b1);
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (tail_ff == head_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               tail_in = tail_next;
               if (edit.finish) begin
                  idx_in   = '0;
                  state_in = ST_EMIT;
               end else if (edit.erase) begin
                  len_in = len_ff - 1'b1;
               end else if (edit.append) begin
                  line_we = 1'b1;
                  len_in  = len_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_ready_in = 1'b1;
            rsp_char_in  = line_rd_ff;
            rsp_idx_in   = idx_ff;
            rsp_last_in  = (idx_ff == len_ff - 1'b1);
            idx_in       = idx_ff + 1'b1;
            if (rsp_last_in) begin
               len_in   = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         len_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         len_ff       <= len_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      limit_ff     <= limit_in;
      idx_ff       <= idx_in;
      rsp_ready_ff <= rsp_ready_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[head_ff] <= req_rx_data;
      end
      ring_rd_ff <= ring_mem[ring_rd_addr];
   end

   // line memory
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[len_ff] <= ring_rd_ff;
      end
      line_rd_ff <= line_mem[line_rd_addr];
   end

   // response ports
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_ready = rsp_ready_ff;
   assign rsp_line_char  = rsp_char_ff;
   assign rsp_char_index = 6'(rsp_idx_ff);
   assign rsp_last       = rsp_last_ff;

endmodule
